/* src/tcrtu_pkg.sv */
// Package for the three-channel reload timer unit.
// Command codes, control register layout and prescaler decode.
// No dependencies.
`default_nettype none

package tcrtu_pkg;

	localparam int DATA_W = 32;
	localparam int CMD_W  = 2;
	localparam int SEL_W  = 4;
	localparam int PSC_W  = 10;
	localparam int PCODE_W = 3;
	localparam int IRQ_W  = 3;

	localparam int DEF_NUM_TIMERS  = 3;
	localparam int DEF_COUNT_WIDTH = 32;

	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [SEL_W-1:0] SEL_START = 4'd0;

	// control register bit positions
	localparam int CTL_UNIE_BIT = 5;
	localparam int CTL_UNF_BIT  = 8;

	localparam logic [PCODE_W-1:0] PSC_DIV4    = 3'd0;
	localparam logic [PCODE_W-1:0] PSC_DIV16   = 3'd1;
	localparam logic [PCODE_W-1:0] PSC_DIV64   = 3'd2;
	localparam logic [PCODE_W-1:0] PSC_DIV256  = 3'd3;
	localparam logic [PCODE_W-1:0] PSC_DIV1024 = 3'd4;

	// last prescaler count before the timer counter moves; prohibited codes divide by 1
	function automatic logic [PSC_W-1:0] presc_last(input logic [PCODE_W-1:0] code);
		logic [PSC_W-1:0] last;
		case (code)
			PSC_DIV4:    last = 10'd3;
			PSC_DIV16:   last = 10'd15;
			PSC_DIV64:   last = 10'd63;
			PSC_DIV256:  last = 10'd255;
			PSC_DIV1024: last = 10'd1023;
			default:     last = 10'd0;
		endcase
		return last;
	endfunction

endpackage

`default_nettype wire

/* src/three_channel_reload_timer_unit.sv */
// Three-channel down-counting reload timer unit.
// Uses tcrtu_pkg for command codes, register layout and prescaler decode.
//
//   channel  direction  handshake            payload
//   in       request in in_valid / in_stall  command, reg_select, write_data
//   out      result out out_valid / out_stall read_data, irq_lines
//
// One request per cycle sustained while out_stall is low: a request is held in the
// input register, its state update and result are formed in a single pass and
// land in the output register, which drives out_valid.
// Reset restores all timer state at once; no clearing pass is needed.
// A stalled result holds the output register; the input register then holds
// one more request and in_stall rises only while both are full.
`default_nettype none

module three_channel_reload_timer_unit #(
	parameter int NUM_TIMERS  = tcrtu_pkg::DEF_NUM_TIMERS,
	parameter int COUNT_WIDTH = tcrtu_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [tcrtu_pkg::CMD_W-1:0]    command,
	input  wire logic [tcrtu_pkg::SEL_W-1:0]    reg_select,
	input  wire logic [tcrtu_pkg::DATA_W-1:0]   write_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [tcrtu_pkg::DATA_W-1:0]        read_data,
	output logic [tcrtu_pkg::IRQ_W-1:0]         irq_lines
);
	import tcrtu_pkg::*;

	localparam int IRQ_N = (NUM_TIMERS < IRQ_W) ? NUM_TIMERS : IRQ_W;

	// input register
	logic               valid_s1;
	logic [CMD_W-1:0]   command_s1;
	logic [SEL_W-1:0]   reg_select_s1;
	logic [DATA_W-1:0]  write_data_s1;

	// timer state
	logic [NUM_TIMERS-1:0]  start_q;
	logic [COUNT_WIDTH-1:0] reload_q [NUM_TIMERS];
	logic [COUNT_WIDTH-1:0] count_q  [NUM_TIMERS];
	logic [PCODE_W-1:0]     pcode_q  [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]  unie_q;
	logic [NUM_TIMERS-1:0]  unf_q;
	logic [PSC_W-1:0]       pscnt_q  [NUM_TIMERS];

	logic [NUM_TIMERS-1:0]  start_n;
	logic [COUNT_WIDTH-1:0] reload_n [NUM_TIMERS];
	logic [COUNT_WIDTH-1:0] count_n  [NUM_TIMERS];
	logic [PCODE_W-1:0]     pcode_n  [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]  unie_n;
	logic [NUM_TIMERS-1:0]  unf_n;
	logic [PSC_W-1:0]       pscnt_n  [NUM_TIMERS];

	logic [DATA_W-1:0] rd_n;
	logic [IRQ_W-1:0]  irq_n;

	// output register
	logic               out_valid_q;
	logic [DATA_W-1:0]  read_data_q;
	logic [IRQ_W-1:0]   irq_q;

	logic advance;
	logic accept;
	logic is_tick;
	logic is_wr;
	logic is_rd;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign is_tick = (command_s1 == CMD_TICK);
	assign is_wr   = (command_s1 == CMD_WRITE);
	assign is_rd   = (command_s1 == CMD_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1    <= command;
			reg_select_s1 <= reg_select;
			write_data_s1 <= write_data;
		end
	end

	always_comb begin
		logic sel_rl;
		logic sel_cnt;
		logic sel_ctl;
		start_n = start_q;
		unie_n  = unie_q;
		unf_n   = unf_q;
		rd_n    = '0;
		if (reg_select_s1 == SEL_START) begin
			if (is_wr) begin
				start_n = write_data_s1[NUM_TIMERS-1:0];
			end
			if (is_rd) begin
				rd_n = DATA_W'(start_q);
			end
		end
		for (int i = 0; i < NUM_TIMERS; i++) begin
			sel_rl  = (DATA_W'(reg_select_s1) == DATA_W'(1 + 3 * i));
			sel_cnt = (DATA_W'(reg_select_s1) == DATA_W'(2 + 3 * i));
			sel_ctl = (DATA_W'(reg_select_s1) == DATA_W'(3 + 3 * i));
			reload_n[i] = reload_q[i];
			count_n[i]  = count_q[i];
			pcode_n[i]  = pcode_q[i];
			pscnt_n[i]  = pscnt_q[i];
			if (is_tick && start_q[i]) begin
				if (pscnt_q[i] < presc_last(pcode_q[i])) begin
					pscnt_n[i] = pscnt_q[i] + 1'b1;
				end else begin
					pscnt_n[i] = '0;
					// reload on the way through zero
					if (count_q[i] <= COUNT_WIDTH'(1)) begin
						count_n[i] = count_q[i] + reload_q[i] - COUNT_WIDTH'(1);
						unf_n[i]   = 1'b1;
					end else begin
						count_n[i] = count_q[i] - COUNT_WIDTH'(1);
					end
				end
			end
			if (is_wr) begin
				if (reg_select_s1 == SEL_START && write_data_s1[i] != start_q[i]) begin
					pscnt_n[i] = '0;
				end
				if (sel_rl) begin
					reload_n[i] = write_data_s1[COUNT_WIDTH-1:0];
				end
				if (sel_cnt) begin
					count_n[i] = write_data_s1[COUNT_WIDTH-1:0];
				end
				if (sel_ctl) begin
					if (pcode_q[i] != write_data_s1[PCODE_W-1:0]) begin
						pscnt_n[i] = '0;
					end
					pcode_n[i] = write_data_s1[PCODE_W-1:0];
					unie_n[i]  = write_data_s1[CTL_UNIE_BIT];
					// flag can only be cleared
					unf_n[i]   = unf_q[i] && write_data_s1[CTL_UNF_BIT];
				end
			end
			if (is_rd) begin
				if (sel_rl) begin
					rd_n = DATA_W'(reload_q[i]);
				end
				if (sel_cnt) begin
					rd_n = DATA_W'(count_q[i]);
				end
				if (sel_ctl) begin
					rd_n = '0;
					rd_n[PCODE_W-1:0]  = pcode_q[i];
					rd_n[CTL_UNIE_BIT] = unie_q[i];
					rd_n[CTL_UNF_BIT]  = unf_q[i];
				end
			end
		end
		irq_n = '0;
		for (int i = 0; i < IRQ_N; i++) begin
			irq_n[i] = unf_n[i] && unie_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			unie_q  <= '0;
			unf_q   <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				reload_q[i] <= '1;
				count_q[i]  <= '1;
				pcode_q[i]  <= '0;
				pscnt_q[i]  <= '0;
			end
		end else if (advance) begin
			start_q <= start_n;
			unie_q  <= unie_n;
			unf_q   <= unf_n;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				reload_q[i] <= reload_n[i];
				count_q[i]  <= count_n[i];
				pcode_q[i]  <= pcode_n[i];
				pscnt_q[i]  <= pscnt_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rd_n;
			irq_q       <= irq_n;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign irq_lines = irq_q;

	// the input side only stalls with a request held behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("in_stall without a blocked result");

	// a blocked result keeps the held request and the timer state
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |=>
		(valid_s1 && $stable(command_s1) && $stable(start_q) && $stable(unf_q)))
		else $error("state moved while result blocked");

	generate
		for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_chk
			a_psc_range: assert property (@(posedge clk) disable iff (!arst_n)
				pscnt_q[g] <= presc_last(pcode_q[g]))
				else $error("prescaler count beyond its divide ratio");
		end
	endgenerate

endmodule

`default_nettype wire
